### hdl/mec_pkg.sv
// ----------------------------------------------------------------------------
// mec_pkg: shared constants for the Mandelbrot escape-count core
// Field widths, register map and register reset values.
// ----------------------------------------------------------------------------
package mec_pkg;

    // Fixed field widths
    localparam int DIM_W  = 13;   // image_width / image_height registers
    localparam int PIX_W  = 12;   // pixel_col / pixel_row
    localparam int ITER_W = 16;   // max_iterations register

    // Configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_MAX_ITERATIONS = 2'd2
    } reg_idx_t;

    // Register reset values
    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH    = 13'd640;
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT   = 13'd480;
    localparam logic [ITER_W-1:0] RST_MAX_ITERATIONS = 16'd256;

endpackage

### hdl/mec_div.sv
// ----------------------------------------------------------------------------
// mec_div: restoring divider for the pixel-to-plane mapping
// Divides {dividend, FRAC_BITS+1 zero bits} by divisor, one quotient bit per
// cycle. done pulses for one cycle when the quotient is valid.
// ----------------------------------------------------------------------------
module mec_div #(
    parameter int FRAC_BITS = 28
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [mec_pkg::DIM_W-1:0]              dividend,
    input  logic [mec_pkg::DIM_W-1:0]              divisor,
    output logic                                   done,
    output logic [mec_pkg::DIM_W+FRAC_BITS:0]      quotient
);

    localparam int DW = mec_pkg::DIM_W;
    localparam int QW = DW + FRAC_BITS + 1;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0] acc_reg;     // dividend bits shifting out, quotient bits in
    logic [DW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          qbit;

    // Trial subtract
    assign shifted = {rem_reg, acc_reg[QW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor};
    assign qbit    = ~diff[DW+1];

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(QW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - CW'(1);
                done_reg <= (cnt_reg == CW'(1));
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= {dividend, {(FRAC_BITS + 1){1'b0}}};
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= {acc_reg[QW-2:0], qbit};
            rem_reg <= qbit ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

### hdl/mandelbrot_escape_count_core.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_count_core: Mandelbrot escape-time counter
// Maps a pixel to a point c, iterates z = z^2 + c with one shared multiplier
// and reports the iteration count and an in-set flag.
// ----------------------------------------------------------------------------
// Sequence: two divisions (real part, then imaginary part), then the iteration
//   loop; done rises when the limit or the bounds check ends the loop, or when
//   the magnitude test does.
// Throughput: one pixel at a time; busy for the whole transaction (divider, then
//   one shared multiplier, 3 products per iteration). The receiver cannot stall.
// Reset: asynchronous, active low; registers return to 640/480/256, idle.
// ----------------------------------------------------------------------------
module mandelbrot_escape_count_core #(
    parameter int MAX_DIM    = 4096,
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 28
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mec_pkg::APB_AW-1:0]    paddr,
    input  logic [mec_pkg::APB_DW-1:0]    pwdata,
    output logic [mec_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    // Command
    input  logic                          start,
    output logic                          busy,
    input  logic [mec_pkg::PIX_W-1:0]     pixel_col,
    input  logic [mec_pkg::PIX_W-1:0]     pixel_row,
    // Result
    output logic                          done,
    output logic [COUNT_BITS-1:0]         escape_count,
    output logic                          in_set
);

    localparam int DW  = mec_pkg::DIM_W;
    localparam int QW  = DW + FRAC_BITS + 1;   // divider quotient width
    localparam int ZW  = FRAC_BITS + 5;        // x, y, c: |v| <= 12.0
    localparam int MW  = FRAC_BITS + 3;        // multiplier operand: |v| <= 2.0
    localparam int PW  = 2 * MW;
    localparam int NW  = DW + 2;               // 2*pos - span
    localparam int LW  = (COUNT_BITS > mec_pkg::ITER_W) ? COUNT_BITS : mec_pkg::ITER_W;

    localparam logic signed [ZW-1:0] TWO    = ZW'(2) <<< FRAC_BITS;
    localparam logic signed [ZW-1:0] M_TWO  = -TWO;
    localparam logic signed [ZW:0]   FOUR   = (ZW + 1)'(4) <<< FRAC_BITS;
    localparam logic [QW-1:0]        C_LIM  = QW'(1) << (FRAC_BITS + 3);
    localparam logic [LW-1:0]        C_MAX  = LW'((64'd1 << COUNT_BITS) - 64'd1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_RE,
        S_DIV_IM,
        S_TEST,
        S_SQ_Y,
        S_SQ_XY,
        S_UPD
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DW-1:0]              width_reg;
    logic [DW-1:0]              height_reg;
    logic [mec_pkg::ITER_W-1:0] max_it_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mec_pkg::RST_IMAGE_WIDTH;
            height_reg <= mec_pkg::RST_IMAGE_HEIGHT;
            max_it_reg <= mec_pkg::RST_MAX_ITERATIONS;
        end
        else if (cfg_wr)
        begin
            case (mec_pkg::reg_idx_t'(paddr[3:2]))
                mec_pkg::REG_IMAGE_WIDTH:    width_reg  <= pwdata[DW-1:0];
                mec_pkg::REG_IMAGE_HEIGHT:   height_reg <= pwdata[DW-1:0];
                mec_pkg::REG_MAX_ITERATIONS: max_it_reg <= pwdata[mec_pkg::ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        case (mec_pkg::reg_idx_t'(paddr[3:2]))
            mec_pkg::REG_IMAGE_WIDTH:    prdata = mec_pkg::APB_DW'(width_reg);
            mec_pkg::REG_IMAGE_HEIGHT:   prdata = mec_pkg::APB_DW'(height_reg);
            mec_pkg::REG_MAX_ITERATIONS: prdata = mec_pkg::APB_DW'(max_it_reg);
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective dimensions and limit
    // ------------------------------------------------------------------
    logic [DW-1:0]         w_eff;
    logic [DW-1:0]         h_eff;
    logic [LW-1:0]         max_it_ext;
    logic [COUNT_BITS-1:0] limit_eff;

    always_comb
    begin
        // zero width reads as one, oversized dimensions clip to MAX_DIM
        if (width_reg == '0)
            w_eff = DW'(1);
        else if (32'(width_reg) > 32'(MAX_DIM))
            w_eff = DW'(MAX_DIM);
        else
            w_eff = width_reg;

        if (32'(height_reg) > 32'(MAX_DIM))
            h_eff = DW'(MAX_DIM);
        else
            h_eff = height_reg;

        max_it_ext = LW'(max_it_reg);
        limit_eff  = (max_it_ext > C_MAX) ? COUNT_BITS'(C_MAX) : COUNT_BITS'(max_it_ext);
    end

    // ------------------------------------------------------------------
    // State and datapath registers
    // ------------------------------------------------------------------
    state_t                  state_reg;
    logic                    done_reg;
    logic [COUNT_BITS-1:0]   count_reg;
    logic                    in_set_reg;

    logic [mec_pkg::PIX_W-1:0] row_reg;
    logic [COUNT_BITS-1:0]     limit_reg;
    logic                      neg_reg;
    logic signed [ZW-1:0]      c_re_reg;
    logic signed [ZW-1:0]      c_im_reg;
    logic signed [ZW-1:0]      x_reg;
    logic signed [ZW-1:0]      y_reg;
    logic signed [ZW-1:0]      xx_reg;
    logic signed [ZW-1:0]      yy_reg;
    logic signed [PW-1:0]      prod_reg;

    logic accept;
    assign busy   = (state_reg != S_IDLE);
    assign accept = start & ~busy;

    // ------------------------------------------------------------------
    // Coordinate mapping: numerator select and divider
    // ------------------------------------------------------------------
    logic [mec_pkg::PIX_W-1:0] num_pos;
    logic [DW-1:0]             num_span;
    logic signed [NW-1:0]      num;
    logic                      num_neg;
    logic [NW-1:0]             num_abs;
    logic                      div_start;
    logic                      div_done;
    logic [QW-1:0]             div_q;
    logic [QW-1:0]             q_sat;
    logic signed [ZW-1:0]      c_val;

    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            num_pos  = pixel_col;
            num_span = w_eff;
        end
        else
        begin
            num_pos  = row_reg;
            num_span = h_eff;
        end
        num     = $signed({1'b0, num_pos, 1'b0}) - $signed({2'b00, num_span});
        num_neg = num[NW-1];
        num_abs = num_neg ? NW'(-num) : NW'(num);
    end

    assign div_start = accept | ((state_reg == S_DIV_RE) & div_done);

    mec_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_abs[DW-1:0]),
        .divisor  (w_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    // Saturate to +-8.0 and apply the sign (truncation toward zero)
    always_comb
    begin
        q_sat = (div_q > C_LIM) ? C_LIM : div_q;
        c_val = neg_reg ? -$signed(ZW'(q_sat)) : $signed(ZW'(q_sat));
    end

    // ------------------------------------------------------------------
    // Shared multiplier and iteration arithmetic
    // ------------------------------------------------------------------
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] prod_full;
    logic signed [ZW-1:0] prod_sq;
    logic signed [ZW-1:0] prod_xy2;
    logic signed [ZW:0]   sq_sum;
    logic signed [ZW-1:0] x_new;
    logic signed [ZW-1:0] y_new;
    logic                 out_of_box;
    logic                 at_limit;

    always_comb
    begin
        case (state_reg)
            S_SQ_Y:
            begin
                mul_a = MW'(y_reg);
                mul_b = MW'(y_reg);
            end
            S_SQ_XY:
            begin
                mul_a = MW'(x_reg);
                mul_b = MW'(y_reg);
            end
            default:
            begin
                mul_a = MW'(x_reg);
                mul_b = MW'(x_reg);
            end
        endcase
        prod_full = PW'(mul_a) * PW'(mul_b);
    end

    // Floor to the fixed-point grid; x*y is doubled by shifting one less
    assign prod_sq  = ZW'(prod_reg >>> FRAC_BITS);
    assign prod_xy2 = ZW'(prod_reg >>> (FRAC_BITS - 1));
    assign sq_sum   = (ZW + 1)'(xx_reg) + (ZW + 1)'(yy_reg);
    assign x_new    = xx_reg - yy_reg + c_re_reg;
    assign y_new    = prod_xy2 + c_im_reg;

    assign out_of_box = (x_reg > TWO) || (x_reg < M_TWO) ||
                        (y_reg > TWO) || (y_reg < M_TWO);
    assign at_limit   = (count_reg >= limit_reg);

    // ------------------------------------------------------------------
    // Sequencer: state, count and result strobe
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            in_set_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= '0;
                        state_reg <= S_DIV_RE;
                    end
                end
                S_DIV_RE:
                begin
                    if (div_done)
                        state_reg <= S_DIV_IM;
                end
                S_DIV_IM:
                begin
                    if (div_done)
                        state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    if (at_limit || out_of_box)
                    begin
                        done_reg   <= 1'b1;
                        in_set_reg <= (count_reg == limit_reg);
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SQ_Y;
                    end
                end
                S_SQ_Y:  state_reg <= S_SQ_XY;
                S_SQ_XY: state_reg <= S_UPD;
                S_UPD:
                begin
                    if (sq_sum > FOUR)
                    begin
                        done_reg   <= 1'b1;
                        in_set_reg <= (count_reg == limit_reg);
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        count_reg <= count_reg + COUNT_BITS'(1);
                        state_reg <= S_TEST;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (div_start)
            neg_reg <= num_neg;

        if (accept)
        begin
            row_reg   <= pixel_row;
            limit_reg <= limit_eff;
            x_reg     <= '0;
            y_reg     <= '0;
        end

        if ((state_reg == S_DIV_RE) && div_done)
            c_re_reg <= c_val;
        if ((state_reg == S_DIV_IM) && div_done)
            c_im_reg <= c_val;

        case (state_reg)
            S_TEST:  prod_reg <= prod_full;
            S_SQ_Y:
            begin
                xx_reg   <= prod_sq;
                prod_reg <= prod_full;
            end
            S_SQ_XY:
            begin
                yy_reg   <= prod_sq;
                prod_reg <= prod_full;
            end
            S_UPD:
            begin
                x_reg <= x_new;
                y_reg <= y_new;
            end
            default: ;
        endcase
    end

    assign done         = done_reg;
    assign escape_count = count_reg;
    assign in_set       = in_set_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (count_reg <= limit_reg))
        else $error("escape count beyond the limit");

    a_in_set_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (in_set_reg == (count_reg == limit_reg)))
        else $error("in_set does not match the count");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("not busy after accepting a command");

    a_mul_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQ_Y) |-> !out_of_box)
        else $error("multiplier operand out of range");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for mandelbrot_escape_count_core
// Drives pixel commands and APB register writes, predicts each escape count
// and in-set flag from its own fixed-point model of the iteration, and
// compares every done strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int      COUNT_W      = 16;
    localparam int      FRAC         = 28;
    localparam longint  DIM_LIMIT    = 4096;
    localparam int      QUIET_LIMIT  = 1_000_000;
    localparam int      DRAIN_CYCLES = 400;

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic               in_set;
    } escape_t;

    // ------------------------------------------------------------------------
    // Escape-time predictor and store of outstanding results
    // ------------------------------------------------------------------------
    class escape_tracker;
        bit [mec_pkg::DIM_W-1:0]  width_reg;
        bit [mec_pkg::DIM_W-1:0]  height_reg;
        bit [mec_pkg::ITER_W-1:0] iter_limit;
        escape_t                  pending_escapes[$];
        int unsigned              errors;

        function new();
            width_reg  = mec_pkg::RST_IMAGE_WIDTH;
            height_reg = mec_pkg::RST_IMAGE_HEIGHT;
            iter_limit = mec_pkg::RST_MAX_ITERATIONS;
            errors     = 0;
        endfunction

        function void write_register(mec_pkg::reg_idx_t idx,
                                     logic [mec_pkg::APB_DW-1:0] value);
            case (idx)
                mec_pkg::REG_IMAGE_WIDTH:    width_reg  = value[mec_pkg::DIM_W-1:0];
                mec_pkg::REG_IMAGE_HEIGHT:   height_reg = value[mec_pkg::DIM_W-1:0];
                mec_pkg::REG_MAX_ITERATIONS: iter_limit = value[mec_pkg::ITER_W-1:0];
                default: ;
            endcase
        endfunction

        // Pixel offset to plane coordinate, truncated and clamped to +-8.0
        function longint plane_coord(longint offset, longint scale);
            longint bound;
            longint v;
            bound = longint'(8) <<< FRAC;
            v = (offset * (longint'(1) <<< (FRAC + 1))) / scale;
            if (v > bound)
                v = bound;
            if (v < -bound)
                v = -bound;
            return v;
        endfunction

        function escape_t escape_time(logic [mec_pkg::PIX_W-1:0] col,
                                      logic [mec_pkg::PIX_W-1:0] row);
            longint  w, h, lim, c_re, c_im, x, y, xx, yy, xy2, two, four;
            int      n;
            escape_t res;
            w = width_reg;
            h = height_reg;
            if (w == 0)
                w = 1;
            if (w > DIM_LIMIT)
                w = DIM_LIMIT;
            if (h > DIM_LIMIT)
                h = DIM_LIMIT;
            lim  = iter_limit;
            two  = longint'(2) <<< FRAC;
            four = longint'(4) <<< FRAC;
            c_re = plane_coord(2 * longint'(col) - w, w);
            c_im = plane_coord(2 * longint'(row) - h, w);
            x = 0;
            y = 0;
            n = 0;
            // z = z^2 + c, products floored to the fraction width
            while (n < lim) begin
                if (x > two || x < -two || y > two || y < -two)
                    break;
                xx = (x * x) >>> FRAC;
                yy = (y * y) >>> FRAC;
                if (xx + yy > four)
                    break;
                xy2 = (2 * x * y) >>> FRAC;
                x = xx - yy + c_re;
                y = xy2 + c_im;
                n++;
            end
            res.count  = n[COUNT_W-1:0];
            res.in_set = (n == lim);
            return res;
        endfunction

        function void note_pixel(logic [mec_pkg::PIX_W-1:0] col,
                                 logic [mec_pkg::PIX_W-1:0] row);
            pending_escapes.push_back(escape_time(col, row));
        endfunction

        function void check_result(logic [COUNT_W-1:0] count, logic flag);
            escape_t want;
            if (pending_escapes.size() == 0) begin
                $error("escape result with no pixel outstanding: count %0d in_set %0b",
                       count, flag);
                errors++;
                return;
            end
            want = pending_escapes.pop_front();
            if (count !== want.count) begin
                $error("escape_count: expected %0d, actual %0d", want.count, count);
                errors++;
            end
            if (flag !== want.in_set) begin
                $error("in_set: expected %0b, actual %0b", want.in_set, flag);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [mec_pkg::APB_AW-1:0]   paddr;
    logic [mec_pkg::APB_DW-1:0]   pwdata;
    logic [mec_pkg::APB_DW-1:0]   prdata;
    logic                         pready;
    logic                         start;
    logic                         busy;
    logic [mec_pkg::PIX_W-1:0]    pixel_col;
    logic [mec_pkg::PIX_W-1:0]    pixel_row;
    logic                         done;
    logic [COUNT_W-1:0]           escape_count;
    logic                         in_set;

    escape_tracker tracker;
    int            idle_pct;
    int            view_w;
    int            view_h;
    int            quiet_cycles;

    mandelbrot_escape_count_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .pixel_col    (pixel_col),
        .pixel_row    (pixel_row),
        .done         (done),
        .escape_count (escape_count),
        .in_set       (in_set)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Result monitor and watchdog on accepted transactions
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n === 1'b1) begin
            if (done === 1'b1)
                tracker.check_result(escape_count, in_set);
            if (done === 1'b1 || (start === 1'b1 && busy === 1'b0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // APB write: setup cycle, access cycle until pready, then back to idle
    task automatic write_register(mec_pkg::reg_idx_t idx,
                                  logic [mec_pkg::APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        tracker.write_register(idx, value);
    endtask

    // Pixel command; returns in the step of the accepting edge
    task automatic send_pixel(int col, int row);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        pixel_col <= col[mec_pkg::PIX_W-1:0];
        pixel_row <= row[mec_pkg::PIX_W-1:0];
        do
            @(posedge clk);
        while (busy !== 1'b0);
        tracker.note_pixel(col[mec_pkg::PIX_W-1:0], row[mec_pkg::PIX_W-1:0]);
    endtask

    // Drop start and wait until every outstanding result is back
    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending_escapes.size() != 0 || busy !== 1'b0);
    endtask

    task automatic apply_setting(int w, int h, int lim);
        wait_idle();
        write_register(mec_pkg::REG_IMAGE_WIDTH, w);
        write_register(mec_pkg::REG_IMAGE_HEIGHT, h);
        write_register(mec_pkg::REG_MAX_ITERATIONS, lim);
        view_w = (w == 0) ? 1 : ((w > DIM_LIMIT) ? DIM_LIMIT : w);
        view_h = (h == 0) ? 1 : ((h > DIM_LIMIT) ? DIM_LIMIT : h);
    endtask

    // Random register setting; limits kept short except now and then
    task automatic pick_setting();
        int w, h, lim;
        case ($urandom_range(9))
            0:       w = $urandom_range(8191);
            1:       w = $urandom_range(1, 16);
            default: w = $urandom_range(1, 4096);
        endcase
        case ($urandom_range(9))
            0:       h = $urandom_range(8191);
            1:       h = $urandom_range(0, 16);
            default: h = $urandom_range(1, 4096);
        endcase
        lim = ($urandom_range(9) == 0) ? $urandom_range(200, 600) : $urandom_range(0, 64);
        apply_setting(w, h, lim);
    endtask

    // Mostly pixels inside the image, the rest anywhere in the field range
    task automatic random_phase(int n_items);
        int col, row;
        repeat (n_items) begin
            if ($urandom_range(99) < 85) begin
                col = $urandom_range(view_w - 1);
                row = $urandom_range(view_h - 1);
            end
            else begin
                col = $urandom_range(4095);
                row = $urandom_range(4095);
            end
            send_pixel(col, row);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int modes[3];
        tracker      = new();
        quiet_cycles = 0;
        idle_pct     = 36;
        view_w       = mec_pkg::RST_IMAGE_WIDTH;
        view_h       = mec_pkg::RST_IMAGE_HEIGHT;
        modes        = '{36, 83, 0};
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        start     <= 1'b0;
        pixel_col <= '0;
        pixel_row <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: origin, c = -1, image corners, pixels off the image
        send_pixel(320, 240);
        send_pixel(160, 240);
        send_pixel(0, 0);
        send_pixel(639, 479);
        send_pixel(0, 479);
        send_pixel(639, 0);
        send_pixel(4095, 4095);
        send_pixel(4095, 0);
        send_pixel(0, 4095);

        // Zero width taken as one, oversized height, zero limit
        apply_setting(0, 8191, 0);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(2048, 2048);

        // c = -2 sits exactly on the |z|^2 = 4 boundary; c = 2 and c = 6 escape; row 4095 saturates
        apply_setting(1, 0, 256);
        send_pixel(0, 0);
        send_pixel(1, 0);
        send_pixel(2, 0);
        send_pixel(0, 4095);

        // Largest image and largest limit: the origin runs the full count
        apply_setting(8191, 4096, 65535);
        send_pixel(2048, 2048);
        send_pixel(0, 0);
        send_pixel(4095, 4095);

        // Limit of one
        apply_setting(3, 7, 1);
        send_pixel(1, 3);
        send_pixel(0, 0);

        // Random part: three idling modes, several settings each
        foreach (modes[m]) begin
            idle_pct = modes[m];
            repeat (4) begin
                pick_setting();
                random_phase(100);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_escapes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
